### src/vrl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// vrl_pkg: shared types and constants of the VSWR / return loss converter
// Fixed-point formats, word kinds and the request/response bundles that
// pass between the sequencer and its arithmetic units.
// ============================================================================
package vrl_pkg;

    // Fixed-point formats.
    localparam int GAMMA_FRAC_BITS = 16;
    localparam int DB_FRAC_BITS    = 8;
    localparam int VSWR_MAX        = 1000;
    localparam int VSWR_FRAC       = 8;

    // Log unit: Q1.30 mantissa, Q.24 log2, Q.52 dB product.
    localparam int LOG_FRAC   = 24;
    localparam int NORM_FRAC  = 30;
    localparam int PROD_FRAC  = 52;
    localparam int PROD_SHIFT = PROD_FRAC - DB_FRAC_BITS;

    // Divider sizes.
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 18;

    localparam logic [16:0] GAMMA_ONE = 17'(1 << GAMMA_FRAC_BITS);
    localparam logic [17:0] VSWR_ONE  = 18'(1 << VSWR_FRAC);
    localparam logic [17:0] VSWR_CAP  = 18'(VSWR_MAX << VSWR_FRAC);
    localparam logic signed [15:0] DB_FLOOR = 16'(-(100 << DB_FRAC_BITS));
    localparam logic [16:0] DB_FLOOR_MAG = 17'(100 << DB_FRAC_BITS);

    // 20*log10(2) in Q.28.
    localparam logic [30:0] LOG_K = 31'd1616142483;
    // Unrounded dB magnitude of the smallest nonzero gamma.
    localparam logic [59:0] MAG_ONE =
        (60'(LOG_K) * 60'(GAMMA_FRAC_BITS)) << LOG_FRAC;
    localparam logic [59:0] DB_HALF = 60'(1) << (PROD_SHIFT - 1);

    // Operation codes on the op field.
    localparam logic [1:0] OP_VSWR  = 2'd0;
    localparam logic [1:0] OP_DB    = 2'd1;
    localparam logic [1:0] OP_GAMMA = 2'd2;

    typedef enum logic [1:0] {
        KIND_INVALID,
        KIND_VSWR,
        KIND_DB,
        KIND_GAMMA
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [17:0] vswr;
        logic [15:0] db;
        logic [16:0] gamma;
    } cmd_t;

    typedef struct packed {
        logic        start;
        logic [16:0] g;
    } log_req_t;

    typedef struct packed {
        logic        done;
        logic [59:0] mag;
    } log_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

### src/vrl_front.sv
`timescale 1ns / 1ps
// ============================================================================
// vrl_front: input acceptance and classification
// Checks the given quantity against its legal range and forms a queue word.
// ============================================================================
module vrl_front (
    input  logic               start,
    input  logic [1:0]         op,
    input  logic [17:0]        vswr_in,
    input  logic signed [15:0] s11_db_in,
    input  logic signed [17:0] gamma_in,
    input  logic               full,
    output logic               busy,
    output logic               push,
    output vrl_pkg::cmd_t      cmd
);
    import vrl_pkg::*;

    // The queue being full is the only reason to hold off a new word.
    assign busy = full;
    assign push = start && !full;

    // Range checks select the word kind.
    always_comb
    begin
        cmd.vswr  = vswr_in;
        cmd.db    = s11_db_in;
        cmd.gamma = gamma_in[16:0];
        unique case (op)
            OP_VSWR:
                cmd.kind = (vswr_in >= VSWR_ONE && vswr_in <= VSWR_CAP) ?
                           KIND_VSWR : KIND_INVALID;
            OP_DB:
                cmd.kind = (s11_db_in <= 16'sd0 && s11_db_in >= DB_FLOOR) ?
                           KIND_DB : KIND_INVALID;
            OP_GAMMA:
                cmd.kind = (!gamma_in[17] && gamma_in[16:0] <= GAMMA_ONE) ?
                           KIND_GAMMA : KIND_INVALID;
            default:
                cmd.kind = KIND_INVALID;
        endcase
    end

endmodule

### src/vrl_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// vrl_queue: two-word queue between front and back
// Lets the front take a new word while the back is still working.
// ============================================================================
module vrl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vrl_pkg::cmd_t push_cmd,
    input  logic          pop,
    output vrl_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import vrl_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### src/vrl_log.sv
`timescale 1ns / 1ps
// ============================================================================
// vrl_log: sequential dB magnitude unit
// Forms |log2(g)| by one squaring per cycle, then scales it to dB in Q.52.
// ============================================================================
module vrl_log (
    input  logic              clk,
    input  logic              rst_n,
    input  vrl_pkg::log_req_t req,
    output vrl_pkg::log_rsp_t rsp
);
    import vrl_pkg::*;

    typedef enum logic [1:0] {L_IDLE, L_ITER, L_FIN, L_MUL} lstate_t;

    lstate_t              state_reg;
    logic [30:0]          x_reg;
    logic [LOG_FRAC-1:0]  frac_reg;
    logic [4:0]           p_reg;
    logic [4:0]           cnt_reg;
    logic [28:0]          lmag_reg;
    logic [59:0]          mag_reg;
    logic                 done_reg;

    logic [4:0]  p_c;
    logic [61:0] sq_c;
    logic [59:0] prod_c;

    // Position of the leading one of gamma.
    always_comb
    begin
        p_c = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (req.g[i])
            begin
                p_c = 5'(i);
            end
        end
    end

    assign sq_c   = 62'(x_reg) * 62'(x_reg);
    assign prod_c = 60'(lmag_reg) * 60'(LOG_K);

    assign rsp.done = done_reg;
    assign rsp.mag  = mag_reg;

    // Normalize, square 24 times, subtract, scale.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            x_reg     <= '0;
            frac_reg  <= '0;
            p_reg     <= '0;
            cnt_reg   <= '0;
            lmag_reg  <= '0;
            mag_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (req.start)
                    begin
                        x_reg     <= 31'(req.g) << (5'(NORM_FRAC) - p_c);
                        p_reg     <= p_c;
                        frac_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= L_ITER;
                    end
                end
                L_ITER:
                begin
                    // A square at or above two gives a one bit and is halved.
                    if (sq_c[61])
                    begin
                        x_reg <= sq_c[61:31];
                    end
                    else
                    begin
                        x_reg <= sq_c[60:30];
                    end
                    frac_reg <= {frac_reg[LOG_FRAC-2:0], sq_c[61]};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(LOG_FRAC - 1))
                    begin
                        state_reg <= L_FIN;
                    end
                end
                L_FIN:
                begin
                    lmag_reg  <= {5'(GAMMA_FRAC_BITS) - p_reg, {LOG_FRAC{1'b0}}}
                                 - {5'd0, frac_reg};
                    state_reg <= L_MUL;
                end
                L_MUL:
                begin
                    mag_reg   <= prod_c;
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

endmodule

### src/vrl_div.sv
`timescale 1ns / 1ps
// ============================================================================
// vrl_div: bit-serial restoring divider
// Produces one quotient bit per cycle for an unsigned 34 by 18 bit division.
// ============================================================================
module vrl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  vrl_pkg::div_req_t req,
    output vrl_pkg::div_rsp_t rsp
);
    import vrl_pkg::*;

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t              state_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [5:0]           cnt_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0] trial_c;
    logic               fit_c;

    assign trial_c = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fit_c   = (trial_c >= {1'b0, den_reg});

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    // One subtract-and-compare step per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            num_reg   <= '0;
            quo_reg   <= '0;
            den_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        num_reg   <= req.num;
                        den_reg   <= req.den;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    if (fit_c)
                    begin
                        rem_reg <= DIV_DEN_W'(trial_c - {1'b0, den_reg});
                    end
                    else
                    begin
                        rem_reg <= trial_c[DIV_DEN_W-1:0];
                    end
                    quo_reg <= {quo_reg[DIV_NUM_W-2:0], fit_c};
                    num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DIV_NUM_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

### src/vrl_back.sv
`timescale 1ns / 1ps
// ============================================================================
// vrl_back: conversion sequencer
// Takes queue words and drives the divider and the log unit to derive the
// two missing quantities, then presents the result word for one cycle.
// ============================================================================
module vrl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  vrl_pkg::cmd_t      head,
    output logic               pop,
    output logic               done,
    output logic [16:0]        gamma_out,
    output logic signed [15:0] s11_db_out,
    output logic [17:0]        vswr_out,
    output logic               input_invalid,
    output logic               db_minus_infinite,
    output logic               vswr_infinite,
    output logic               vswr_saturated
);
    import vrl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVG_GO, S_DIVG, S_SRCH, S_SRCH_W, S_FINE_W,
        S_POST, S_DB_W, S_VS_W, S_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [16:0] g_reg, g_next;
    logic [15:0] db_reg, db_next;
    logic [17:0] vo_reg, vo_next;
    logic        inv_reg, inv_next;
    logic        minf_reg, minf_next;
    logic        vinf_reg, vinf_next;
    logic        vsat_reg, vsat_next;
    logic        need_db_reg, need_db_next;
    logic        need_vs_reg, need_vs_next;
    logic [59:0] target_reg, target_next;
    logic [16:0] lo_reg, lo_next;
    logic [16:0] hi_reg, hi_next;
    logic [16:0] mid_reg, mid_next;
    logic [59:0] lomag_reg, lomag_next;
    logic        done_reg, done_next;
    logic [16:0] gout_reg, gout_next;
    logic [15:0] dbout_reg, dbout_next;
    logic [17:0] vout_reg, vout_next;
    logic        oinv_reg, oinv_next;
    logic        ominf_reg, ominf_next;
    logic        ovinf_reg, ovinf_next;
    logic        ovsat_reg, ovsat_next;

    log_req_t log_req;
    log_rsp_t log_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [15:0]             dbmag_c;
    logic [59:0]             target_c;
    logic [16:0]             span_c;
    logic [16:0]             mid_c;
    logic [16:0]             lo_inc_c;
    logic [60:0]             rnd_c;
    logic [60-PROD_SHIFT:0]  m_c;
    logic [59:0]             dlo_c;
    logic [59:0]             dhi_c;
    logic [17:0]             vden_c;
    logic [17:0]             gden_c;

    vrl_log u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    vrl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Datapath helpers.
    assign dbmag_c  = 16'd0 - head.db;
    assign target_c = 60'(dbmag_c) << PROD_SHIFT;
    assign span_c   = hi_reg - lo_reg + 17'd1;
    assign mid_c    = lo_reg + (span_c >> 1);
    assign lo_inc_c = lo_reg + 17'd1;
    assign rnd_c    = 61'(log_rsp.mag) + 61'(DB_HALF);
    assign m_c      = rnd_c[60:PROD_SHIFT];
    assign dlo_c    = lomag_reg - target_reg;
    assign dhi_c    = target_reg - log_rsp.mag;
    assign vden_c   = vo_reg + VSWR_ONE;
    assign gden_c   = 18'(GAMMA_ONE - g_reg);

    assign pop = (state_reg == S_IDLE) && !empty;

    // Sequencer next-state and unit requests.
    always_comb
    begin
        state_next   = state_reg;
        g_next       = g_reg;
        db_next      = db_reg;
        vo_next      = vo_reg;
        inv_next     = inv_reg;
        minf_next    = minf_reg;
        vinf_next    = vinf_reg;
        vsat_next    = vsat_reg;
        need_db_next = need_db_reg;
        need_vs_next = need_vs_reg;
        target_next  = target_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        lomag_next   = lomag_reg;
        done_next    = 1'b0;
        gout_next    = gout_reg;
        dbout_next   = dbout_reg;
        vout_next    = vout_reg;
        oinv_next    = oinv_reg;
        ominf_next   = ominf_reg;
        ovinf_next   = ovinf_reg;
        ovsat_next   = ovsat_reg;
        log_req.start = 1'b0;
        log_req.g     = g_reg;
        div_req.start = 1'b0;
        div_req.num   = ((DIV_NUM_W'(GAMMA_ONE) + DIV_NUM_W'(g_reg)) << VSWR_FRAC)
                        + DIV_NUM_W'(gden_c >> 1);
        div_req.den   = gden_c;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    g_next    = '0;
                    db_next   = '0;
                    vo_next   = '0;
                    inv_next  = 1'b0;
                    minf_next = 1'b0;
                    vinf_next = 1'b0;
                    vsat_next = 1'b0;
                    unique case (head.kind)
                        KIND_INVALID:
                        begin
                            inv_next   = 1'b1;
                            state_next = S_EMIT;
                        end
                        KIND_VSWR:
                        begin
                            vo_next      = head.vswr;
                            need_db_next = 1'b1;
                            need_vs_next = 1'b0;
                            state_next   = S_DIVG_GO;
                        end
                        KIND_DB:
                        begin
                            db_next      = head.db;
                            need_db_next = 1'b0;
                            need_vs_next = 1'b1;
                            target_next  = target_c;
                            // Below the smallest gamma the answer is one step.
                            if (MAG_ONE < target_c)
                            begin
                                g_next     = 17'd1;
                                state_next = S_POST;
                            end
                            else
                            begin
                                lo_next    = 17'd1;
                                hi_next    = GAMMA_ONE;
                                lomag_next = MAG_ONE;
                                state_next = S_SRCH;
                            end
                        end
                        KIND_GAMMA:
                        begin
                            g_next       = head.gamma;
                            need_db_next = 1'b1;
                            need_vs_next = 1'b1;
                            state_next   = S_POST;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIVG_GO:
            begin
                // Rounded gamma from VSWR.
                div_req.start = 1'b1;
                div_req.num   = (DIV_NUM_W'(vo_reg - VSWR_ONE) << GAMMA_FRAC_BITS)
                                + DIV_NUM_W'(vden_c >> 1);
                div_req.den   = vden_c;
                state_next    = S_DIVG;
            end
            S_DIVG:
            begin
                if (div_rsp.done)
                begin
                    g_next     = div_rsp.quo[16:0];
                    state_next = S_POST;
                end
            end
            S_SRCH:
            begin
                // Binary search for the largest gamma whose magnitude is still at or above target.
                if (lo_reg < hi_reg)
                begin
                    log_req.start = 1'b1;
                    log_req.g     = mid_c;
                    mid_next      = mid_c;
                    state_next    = S_SRCH_W;
                end
                else if (lo_reg < GAMMA_ONE)
                begin
                    log_req.start = 1'b1;
                    log_req.g     = lo_inc_c;
                    state_next    = S_FINE_W;
                end
                else
                begin
                    g_next     = lo_reg;
                    state_next = S_POST;
                end
            end
            S_SRCH_W:
            begin
                if (log_rsp.done)
                begin
                    if (log_rsp.mag >= target_reg)
                    begin
                        lo_next    = mid_reg;
                        lomag_next = log_rsp.mag;
                    end
                    else
                    begin
                        hi_next = mid_reg - 17'd1;
                    end
                    state_next = S_SRCH;
                end
            end
            S_FINE_W:
            begin
                // Pick the nearer neighbor; a tie keeps the smaller gamma.
                if (log_rsp.done)
                begin
                    g_next     = (dhi_c < dlo_c) ? lo_inc_c : lo_reg;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (need_db_reg)
                begin
                    if (g_reg == 17'd0)
                    begin
                        minf_next    = 1'b1;
                        db_next      = DB_FLOOR;
                        need_db_next = 1'b0;
                    end
                    else
                    begin
                        log_req.start = 1'b1;
                        log_req.g     = g_reg;
                        state_next    = S_DB_W;
                    end
                end
                else if (need_vs_reg)
                begin
                    if (g_reg >= GAMMA_ONE)
                    begin
                        vinf_next  = 1'b1;
                        vo_next    = VSWR_CAP;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_VS_W;
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DB_W:
            begin
                if (log_rsp.done)
                begin
                    if (m_c > DB_FLOOR_MAG)
                    begin
                        db_next = DB_FLOOR;
                    end
                    else
                    begin
                        db_next = 16'(17'd0 - m_c);
                    end
                    need_db_next = 1'b0;
                    state_next   = S_POST;
                end
            end
            S_VS_W:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quo > DIV_NUM_W'(VSWR_CAP))
                    begin
                        vsat_next = 1'b1;
                        vo_next   = VSWR_CAP;
                    end
                    else
                    begin
                        vo_next = div_rsp.quo[17:0];
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                done_next  = 1'b1;
                gout_next  = g_reg;
                dbout_next = db_reg;
                vout_next  = vo_reg;
                oinv_next  = inv_reg;
                ominf_next = minf_reg;
                ovinf_next = vinf_reg;
                ovsat_next = vsat_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            g_reg       <= '0;
            db_reg      <= '0;
            vo_reg      <= '0;
            inv_reg     <= 1'b0;
            minf_reg    <= 1'b0;
            vinf_reg    <= 1'b0;
            vsat_reg    <= 1'b0;
            need_db_reg <= 1'b0;
            need_vs_reg <= 1'b0;
            target_reg  <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            mid_reg     <= '0;
            lomag_reg   <= '0;
            done_reg    <= 1'b0;
            gout_reg    <= '0;
            dbout_reg   <= '0;
            vout_reg    <= '0;
            oinv_reg    <= 1'b0;
            ominf_reg   <= 1'b0;
            ovinf_reg   <= 1'b0;
            ovsat_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            g_reg       <= g_next;
            db_reg      <= db_next;
            vo_reg      <= vo_next;
            inv_reg     <= inv_next;
            minf_reg    <= minf_next;
            vinf_reg    <= vinf_next;
            vsat_reg    <= vsat_next;
            need_db_reg <= need_db_next;
            need_vs_reg <= need_vs_next;
            target_reg  <= target_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            mid_reg     <= mid_next;
            lomag_reg   <= lomag_next;
            done_reg    <= done_next;
            gout_reg    <= gout_next;
            dbout_reg   <= dbout_next;
            vout_reg    <= vout_next;
            oinv_reg    <= oinv_next;
            ominf_reg   <= ominf_next;
            ovinf_reg   <= ovinf_next;
            ovsat_reg   <= ovsat_next;
        end
    end

    assign done              = done_reg;
    assign gamma_out         = gout_reg;
    assign s11_db_out        = dbout_reg;
    assign vswr_out          = vout_reg;
    assign input_invalid     = oinv_reg;
    assign db_minus_infinite = ominf_reg;
    assign vswr_infinite     = ovinf_reg;
    assign vswr_saturated    = ovsat_reg;

endmodule

### src/vswr_return_loss_converter.sv
`timescale 1ns / 1ps
// ============================================================================
// vswr_return_loss_converter: VSWR / S11 dB / gamma conversion
// Given one reflection quantity, derives the other two in fixed point.
// ============================================================================
// Usage:
//   A word is taken at a rising edge with start high and busy low; op picks
//   the given quantity (VSWR, S11 dB or gamma) from its own input port.
//   Each result word appears for exactly one cycle with done high; the
//   receiver cannot stall, so results are never held back.
//   A two-word queue sits behind the input, so new words are taken while a
//   conversion runs; busy is high only while that queue is full.
//   An invalid word goes straight to the result stage. VSWR or gamma given
//   runs the bit-serial divider and the log unit (one squaring per cycle)
//   at most once each. S11 dB given runs a binary search over gamma with
//   one log evaluation per step, up to 17 evaluations and one division.
//   Words are processed one at a time, in order, so the throughput is one
//   word per conversion time.
//   Reset clears the queue and the sequencer; done stays low until the
//   first result.
// ============================================================================
module vswr_return_loss_converter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [17:0]        vswr_in,
    input  logic signed [15:0] s11_db_in,
    input  logic signed [17:0] gamma_in,
    output logic               done,
    output logic [16:0]        gamma_out,
    output logic signed [15:0] s11_db_out,
    output logic [17:0]        vswr_out,
    output logic               input_invalid,
    output logic               db_minus_infinite,
    output logic               vswr_infinite,
    output logic               vswr_saturated
);
    import vrl_pkg::*;

    cmd_t push_cmd;
    cmd_t head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    vrl_front u_front (
        .start     (start),
        .op        (op),
        .vswr_in   (vswr_in),
        .s11_db_in (s11_db_in),
        .gamma_in  (gamma_in),
        .full      (full),
        .busy      (busy),
        .push      (push),
        .cmd       (push_cmd)
    );

    vrl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    vrl_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .empty             (empty),
        .head              (head),
        .pop               (pop),
        .done              (done),
        .gamma_out         (gamma_out),
        .s11_db_out        (s11_db_out),
        .vswr_out          (vswr_out),
        .input_invalid     (input_invalid),
        .db_minus_infinite (db_minus_infinite),
        .vswr_infinite     (vswr_infinite),
        .vswr_saturated    (vswr_saturated)
    );

endmodule
